// ===== design/bar_pkg.sv =====
package bar_pkg;

    // item opcodes
    localparam logic [2:0] OP_BYTE      = 3'd0;
    localparam logic [2:0] OP_REQUEST   = 3'd1;
    localparam logic [2:0] OP_SENT      = 3'd2;
    localparam logic [2:0] OP_START_ERR = 3'd3;
    localparam logic [2:0] OP_RESTART   = 3'd4;

    // arbitration phases
    localparam logic [1:0] PH_OBSERVE = 2'd0;
    localparam logic [1:0] PH_FIRST   = 2'd1;
    localparam logic [1:0] PH_RETRY   = 2'd2;
    localparam logic [1:0] PH_SECOND  = 2'd3;

    // result codes
    localparam logic [3:0] RC_OBSERVE_SYN  = 4'd0;
    localparam logic [3:0] RC_OBSERVE_DATA = 4'd1;
    localparam logic [3:0] RC_FIRST_SYN    = 4'd2;
    localparam logic [3:0] RC_FIRST_WON    = 4'd3;
    localparam logic [3:0] RC_FIRST_RETRY  = 4'd4;
    localparam logic [3:0] RC_FIRST_LOST   = 4'd5;
    localparam logic [3:0] RC_FIRST_ERROR  = 4'd6;
    localparam logic [3:0] RC_RETRY_SYN    = 4'd7;
    localparam logic [3:0] RC_RETRY_ERROR  = 4'd8;
    localparam logic [3:0] RC_SECOND_WON   = 4'd9;
    localparam logic [3:0] RC_SECOND_LOST  = 4'd10;
    localparam logic [3:0] RC_SECOND_ERROR = 4'd11;

    // configuration register indexes
    localparam logic CFG_MAX_LOCK = 1'b0;
    localparam logic CFG_SYN      = 1'b1;

    localparam logic [7:0] LOCK_LIMIT     = 8'd25;
    localparam logic [4:0] MAX_LOCK_RESET = 5'd25;
    localparam logic [7:0] SYN_RESET      = 8'd170;
    localparam logic [7:0] LOW_MASK       = 8'h0f;

    typedef struct packed {
        logic [1:0] phase;
        logic [3:0] last_result;
        logic [4:0] lock;
        logic       pending;
        logic [7:0] addr;
        logic       ext;
    } state_t;

    typedef struct packed {
        logic syn;
        logic own;
        logic master;
        logic same_low;
    } class_t;

    function automatic logic [4:0] clamp_lock(input logic [4:0] v);
        logic [4:0] r;
        r = v;
        if ({3'b000, v} > LOCK_LIMIT)
        begin
            r = LOCK_LIMIT[4:0];
        end
        return r;
    endfunction

    // master address nibbles are 0, 1, 3, 7 or f
    function automatic logic nibble_ok(input logic [3:0] n);
        logic [3:0] inc;
        inc = n + 4'd1;
        return (n & inc) == 4'd0;
    endfunction

    localparam logic [4:0] LOCK_RESET = clamp_lock(MAX_LOCK_RESET);

endpackage

// ===== design/bar_classify.sv =====
module bar_classify (
    input  logic [7:0]      bus_byte,
    input  logic [7:0]      syn_symbol,
    input  logic [7:0]      arb_addr,
    output bar_pkg::class_t cls
);

    always_comb
    begin
        cls.syn      = bus_byte == syn_symbol;
        cls.own      = bus_byte == arb_addr;
        cls.master   = bar_pkg::nibble_ok(bus_byte[3:0]) && bar_pkg::nibble_ok(bus_byte[7:4]);
        cls.same_low = (bus_byte & bar_pkg::LOW_MASK) == (arb_addr & bar_pkg::LOW_MASK);
    end

endmodule

// ===== design/bar_step.sv =====
module bar_step (
    input  bar_pkg::state_t st,
    input  logic [2:0]      opcode,
    input  logic [7:0]      bus_byte,
    input  logic [7:0]      own_address,
    input  logic            external,
    input  logic [4:0]      max_lock,
    input  logic [7:0]      syn_symbol,
    output bar_pkg::state_t nxt,
    output logic            bus_free,
    output logic            notify_handler,
    output logic            notify_external
);

    bar_pkg::class_t cls;
    logic            free_now;

    bar_classify u_classify (
        .bus_byte   (bus_byte),
        .syn_symbol (syn_symbol),
        .arb_addr   (st.addr),
        .cls        (cls)
    );

    assign free_now = (st.last_result == bar_pkg::RC_OBSERVE_SYN) && (st.lock == 5'd0)
                      && !st.pending;

    always_comb
    begin
        nxt             = st;
        notify_handler  = 1'b0;
        notify_external = 1'b0;
        unique case (opcode)
            bar_pkg::OP_BYTE:
            begin
                unique case (st.phase)
                    bar_pkg::PH_OBSERVE:
                    begin
                        if (cls.syn)
                        begin
                            if (st.lock != 5'd0)
                            begin
                                nxt.lock = st.lock - 5'd1;
                            end
                            nxt.last_result = bar_pkg::RC_OBSERVE_SYN;
                        end
                        else
                        begin
                            nxt.last_result = bar_pkg::RC_OBSERVE_DATA;
                        end
                    end
                    bar_pkg::PH_FIRST:
                    begin
                        if (cls.syn)
                        begin
                            nxt.last_result = bar_pkg::RC_FIRST_SYN;
                        end
                        else if (cls.own)
                        begin
                            nxt.lock        = max_lock;
                            nxt.phase       = bar_pkg::PH_OBSERVE;
                            nxt.last_result = bar_pkg::RC_FIRST_WON;
                        end
                        else if (cls.master && cls.same_low)
                        begin
                            nxt.phase       = bar_pkg::PH_RETRY;
                            nxt.pending     = 1'b1;
                            nxt.last_result = bar_pkg::RC_FIRST_RETRY;
                        end
                        else if (cls.master)
                        begin
                            nxt.phase       = bar_pkg::PH_OBSERVE;
                            nxt.last_result = bar_pkg::RC_FIRST_LOST;
                        end
                        else
                        begin
                            nxt.phase       = bar_pkg::PH_OBSERVE;
                            nxt.last_result = bar_pkg::RC_FIRST_ERROR;
                        end
                    end
                    bar_pkg::PH_RETRY:
                    begin
                        if (cls.syn)
                        begin
                            nxt.phase       = bar_pkg::PH_SECOND;
                            nxt.last_result = bar_pkg::RC_RETRY_SYN;
                        end
                        else
                        begin
                            nxt.phase       = bar_pkg::PH_OBSERVE;
                            nxt.last_result = bar_pkg::RC_RETRY_ERROR;
                        end
                    end
                    default:
                    begin
                        // second phase has no syn test
                        if (cls.own)
                        begin
                            nxt.lock        = max_lock;
                            nxt.last_result = bar_pkg::RC_SECOND_WON;
                        end
                        else if (cls.master)
                        begin
                            nxt.last_result = bar_pkg::RC_SECOND_LOST;
                        end
                        else
                        begin
                            nxt.last_result = bar_pkg::RC_SECOND_ERROR;
                        end
                        nxt.phase = bar_pkg::PH_OBSERVE;
                    end
                endcase
            end
            bar_pkg::OP_REQUEST:
            begin
                if (free_now)
                begin
                    nxt.addr    = own_address;
                    nxt.ext     = external;
                    nxt.pending = 1'b1;
                end
            end
            bar_pkg::OP_SENT:
            begin
                nxt.pending = 1'b0;
                if (st.phase == bar_pkg::PH_OBSERVE)
                begin
                    nxt.phase = bar_pkg::PH_FIRST;
                end
                notify_external = st.ext;
                notify_handler  = !st.ext;
            end
            bar_pkg::OP_START_ERR:
            begin
                nxt.pending     = 1'b0;
                nxt.phase       = bar_pkg::PH_OBSERVE;
                nxt.last_result = bar_pkg::RC_OBSERVE_SYN;
            end
            bar_pkg::OP_RESTART:
            begin
                nxt.lock    = max_lock;
                nxt.pending = 1'b0;
                nxt.phase   = bar_pkg::PH_OBSERVE;
            end
            default:
            begin
                nxt = st;
            end
        endcase
    end

    assign bus_free = (nxt.last_result == bar_pkg::RC_OBSERVE_SYN) && (nxt.lock == 5'd0)
                      && !nxt.pending;

endmodule

// ===== design/bus_arbitration_requester.sv =====
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  opcode, bus_byte, own_address, external
// out       output     out_valid / out_stall result_code, request_pending, lock_count,
//                                           phase, bus_free, notify_handler, notify_external
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one transaction accepted per cycle while in_stall is low; out_valid rises once the
// transaction has passed the input register and then the result register; arbitration
// state updates as the item leaves the input register
// asynchronous active-low reset; no clearing pass, the block is ready straight after reset
// a stalled output holds the result register and the input register, and in_stall rises
// only while the input register is full and cannot move on
module bus_arbitration_requester (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] opcode,
    input  logic [7:0] bus_byte,
    input  logic [7:0] own_address,
    input  logic       external,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] result_code,
    output logic       request_pending,
    output logic [4:0] lock_count,
    output logic [1:0] phase,
    output logic       bus_free,
    output logic       notify_handler,
    output logic       notify_external,
    // configuration channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    // configuration registers
    logic [4:0] max_lock_reg;
    logic [7:0] syn_reg;

    // arbitration state
    bar_pkg::state_t state_reg;
    bar_pkg::state_t state_next;

    // input register
    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic [7:0] byte_reg;
    logic [7:0] addr_reg;
    logic       ext_reg;

    // result register
    logic       out_valid_reg;
    logic [3:0] code_reg;
    logic       pending_reg;
    logic [4:0] lock_reg;
    logic [1:0] phase_reg;
    logic       free_reg;
    logic       nh_reg;
    logic       ne_reg;

    logic       free_next;
    logic       nh_next;
    logic       ne_next;

    logic       out_free;
    logic       proc;
    logic       in_take;
    logic       cfg_take;
    logic [4:0] cfg_lock;

    // result register can load when empty or being drained this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign proc      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign cfg_lock  = bar_pkg::clamp_lock(cfg_data[4:0]);

    bar_step u_step (
        .st              (state_reg),
        .opcode          (op_reg),
        .bus_byte        (byte_reg),
        .own_address     (addr_reg),
        .external        (ext_reg),
        .max_lock        (max_lock_reg),
        .syn_symbol      (syn_reg),
        .nxt             (state_next),
        .bus_free        (free_next),
        .notify_handler  (nh_next),
        .notify_external (ne_next)
    );

    // configuration and arbitration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lock_reg          <= bar_pkg::LOCK_RESET;
            syn_reg               <= bar_pkg::SYN_RESET;
            state_reg.phase       <= bar_pkg::PH_OBSERVE;
            state_reg.last_result <= bar_pkg::RC_OBSERVE_SYN;
            state_reg.lock        <= bar_pkg::LOCK_RESET;
            state_reg.pending     <= 1'b0;
            state_reg.addr        <= 8'd0;
            state_reg.ext         <= 1'b0;
        end
        else if (cfg_take)
        begin
            // the user must write only while idle; the block itself does not enforce it
            unique case (cfg_index)
                bar_pkg::CFG_MAX_LOCK:
                begin
                    max_lock_reg <= cfg_lock;
                    if (state_reg.lock > cfg_lock)
                    begin
                        state_reg.lock <= cfg_lock;
                    end
                end
                default:
                begin
                    syn_reg <= cfg_data;
                end
            endcase
        end
        else if (proc)
        begin
            state_reg <= state_next;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= opcode;
            byte_reg <= bus_byte;
            addr_reg <= own_address;
            ext_reg  <= external;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= proc;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            code_reg    <= state_next.last_result;
            pending_reg <= state_next.pending;
            lock_reg    <= state_next.lock;
            phase_reg   <= state_next.phase;
            free_reg    <= free_next;
            nh_reg      <= nh_next;
            ne_reg      <= ne_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_code     = code_reg;
    assign request_pending = pending_reg;
    assign lock_count      = lock_reg;
    assign phase           = phase_reg;
    assign bus_free        = free_reg;
    assign notify_handler  = nh_reg;
    assign notify_external = ne_reg;

    // only one notify pulse per transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(nh_reg && ne_reg))
        else $error("both notify pulses set");

    // free bus means idle result, zero lock count and nothing pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && free_reg) |->
        (!pending_reg && lock_reg == 5'd0 && code_reg == bar_pkg::RC_OBSERVE_SYN))
        else $error("bus free flag inconsistent with status");

    // lock counter never exceeds its reload value
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.lock <= max_lock_reg)
        else $error("lock counter above maximum");

    // a held input transaction is not lost while the result side is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> in_valid_reg && $stable(op_reg))
        else $error("held input transaction dropped");

endmodule

// ===== test/bus_arbitration_requester_tb.sv =====
module bus_arbitration_requester_tb;

    import bar_pkg::*;

    // opcode the block must ignore, used to show that nothing moves
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int CYCLE_LIMIT = 300000;

    // one input transaction
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic [7:0] addr;
        logic       ext;
    } item_t;

    // one result transaction, in port order
    typedef struct packed {
        logic [3:0] code;
        logic       pending;
        logic [4:0] lock;
        logic [1:0] phase;
        logic       free;
        logic       to_handler;
        logic       to_external;
    } status_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // one line of the directed plan
    typedef struct packed {
        row_kind_e kind;
        item_t     it;
        logic      cfg_idx;
        logic [7:0] cfg_val;
        logic      typed;
        status_t   want;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] opcode;
    logic [7:0] bus_byte;
    logic [7:0] own_address;
    logic       external;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] result_code;
    logic       request_pending;
    logic [4:0] lock_count;
    logic [1:0] phase;
    logic       bus_free;
    logic       notify_handler;
    logic       notify_external;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [7:0] cfg_data;

    bus_arbitration_requester dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .bus_byte        (bus_byte),
        .own_address     (own_address),
        .external        (external),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_code     (result_code),
        .request_pending (request_pending),
        .lock_count      (lock_count),
        .phase           (phase),
        .bus_free        (bus_free),
        .notify_handler  (notify_handler),
        .notify_external (notify_external),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // arbitration state as the predictor sees it, reset values of the block
    logic [1:0] cur_phase   = PH_OBSERVE;
    logic [3:0] cur_result  = RC_OBSERVE_SYN;
    logic [4:0] lock_cnt    = LOCK_RESET;
    logic       req_armed   = 1'b0;
    logic [7:0] arb_addr    = 8'h00;
    logic       arb_ext     = 1'b0;
    logic [4:0] lock_max    = LOCK_RESET;
    logic [7:0] syn_byte    = SYN_RESET;

    // results still owed by the block, oldest first
    status_t status_due [$];

    int errors = 0;
    int checked = 0;
    int items_sent = 0;
    int directed_items = 0;
    int reg_writes = 0;
    int cycles = 0;
    int idle_odds = 0;     // one in idle_odds chance of an idle or stall burst, 0 for none
    int stall_left = 0;
    logic [15:0] codes_seen = '0;

    // ------------------------------------------------------------------
    // clock, reset and the cycle limit
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_BYTE;
        bus_byte = 8'h00;
        own_address = 8'h00;
        external = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAX_LOCK;
        cfg_data = 8'h00;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycles,
                     status_due.size());
            $display("bus_arbitration_requester verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // a master address has both nibbles in 0, 1, 3, 7, f
    function automatic logic master_nibble(input logic [3:0] n);
        case (n)
            4'h0, 4'h1, 4'h3, 4'h7, 4'hf: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_master_addr(input logic [7:0] b);
        return master_nibble(b[7:4]) && master_nibble(b[3:0]);
    endfunction

    function automatic logic bus_idle();
        return cur_result == RC_OBSERVE_SYN && lock_cnt == 5'd0 && !req_armed;
    endfunction

    // advances the arbitration state by one transaction, returns the status it gives
    function automatic status_t arbitrate(input item_t it);
        status_t st;
        logic is_syn;
        logic is_own;
        st = '0;
        is_syn = it.data == syn_byte;
        is_own = it.data == arb_addr;
        case (it.op)
            OP_BYTE:
            begin
                case (cur_phase)
                    PH_OBSERVE:
                    begin
                        if (is_syn)
                        begin
                            if (lock_cnt != 5'd0)
                            begin
                                lock_cnt = lock_cnt - 5'd1;
                            end
                            cur_result = RC_OBSERVE_SYN;
                        end
                        else
                        begin
                            cur_result = RC_OBSERVE_DATA;
                        end
                    end
                    PH_FIRST:
                    begin
                        if (is_syn)
                        begin
                            cur_result = RC_FIRST_SYN;
                        end
                        else if (is_own)
                        begin
                            lock_cnt = lock_max;
                            cur_phase = PH_OBSERVE;
                            cur_result = RC_FIRST_WON;
                        end
                        else if (is_master_addr(it.data))
                        begin
                            if (it.data[3:0] == arb_addr[3:0])
                            begin
                                // same priority class: re-arm and try again
                                cur_phase = PH_RETRY;
                                req_armed = 1'b1;
                                cur_result = RC_FIRST_RETRY;
                            end
                            else
                            begin
                                cur_phase = PH_OBSERVE;
                                cur_result = RC_FIRST_LOST;
                            end
                        end
                        else
                        begin
                            cur_phase = PH_OBSERVE;
                            cur_result = RC_FIRST_ERROR;
                        end
                    end
                    PH_RETRY:
                    begin
                        if (is_syn)
                        begin
                            cur_phase = PH_SECOND;
                            cur_result = RC_RETRY_SYN;
                        end
                        else
                        begin
                            cur_phase = PH_OBSERVE;
                            cur_result = RC_RETRY_ERROR;
                        end
                    end
                    default:
                    begin
                        if (is_own)
                        begin
                            lock_cnt = lock_max;
                            cur_result = RC_SECOND_WON;
                        end
                        else if (is_master_addr(it.data))
                        begin
                            cur_result = RC_SECOND_LOST;
                        end
                        else
                        begin
                            cur_result = RC_SECOND_ERROR;
                        end
                        cur_phase = PH_OBSERVE;
                    end
                endcase
            end
            OP_REQUEST:
            begin
                if (bus_idle())
                begin
                    arb_addr = it.addr;
                    arb_ext = it.ext;
                    req_armed = 1'b1;
                end
            end
            OP_SENT:
            begin
                req_armed = 1'b0;
                if (cur_phase == PH_OBSERVE)
                begin
                    cur_phase = PH_FIRST;
                end
                st.to_external = arb_ext;
                st.to_handler = !arb_ext;
            end
            OP_START_ERR:
            begin
                req_armed = 1'b0;
                cur_phase = PH_OBSERVE;
                cur_result = RC_OBSERVE_SYN;
            end
            OP_RESTART:
            begin
                lock_cnt = lock_max;
                req_armed = 1'b0;
                cur_phase = PH_OBSERVE;
            end
            default:
            begin
            end
        endcase
        st.code = cur_result;
        st.pending = req_armed;
        st.lock = lock_cnt;
        st.phase = cur_phase;
        st.free = bus_idle();
        return st;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [3:0] any_master_nibble();
        case ($urandom_range(0, 4))
            0: return 4'h0;
            1: return 4'h1;
            2: return 4'h3;
            3: return 4'h7;
            default: return 4'hf;
        endcase
    endfunction

    // picks the next transaction from the predicted state so that most of the
    // traffic walks well-formed arbitration sequences; the rest is noise
    function automatic item_t next_item();
        item_t it;
        int roll;
        it.op = OP_BYTE;
        it.data = 8'($urandom_range(0, 255));
        it.addr = 8'($urandom_range(0, 255));
        it.ext = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            it.op = 3'($urandom_range(0, 7));
        end
        else
        begin
            case (cur_phase)
                PH_OBSERVE:
                begin
                    if (req_armed)
                    begin
                        it.op = (roll < 16) ? OP_START_ERR : OP_SENT;
                    end
                    else if (bus_idle())
                    begin
                        it.op = OP_REQUEST;
                        if (roll < 85)
                        begin
                            it.addr = {any_master_nibble(), any_master_nibble()};
                        end
                    end
                    else if (roll < 14)
                    begin
                        it.op = OP_RESTART;
                    end
                    else if (roll < 90)
                    begin
                        it.data = syn_byte;
                    end
                end
                PH_FIRST:
                begin
                    case ($urandom_range(0, 5))
                        0: it.data = syn_byte;
                        1: it.data = arb_addr;
                        2: it.data = {any_master_nibble(), arb_addr[3:0]};
                        3:
                        begin
                            it.data = {any_master_nibble(), any_master_nibble()};
                            while (it.data[3:0] == arb_addr[3:0])
                            begin
                                it.data[3:0] = any_master_nibble();
                            end
                        end
                        4: it.op = req_armed ? OP_SENT : OP_BYTE;
                        default:
                        begin
                        end
                    endcase
                end
                PH_RETRY:
                begin
                    if (req_armed && roll < 40)
                    begin
                        it.op = OP_SENT;
                    end
                    else if (roll < 88)
                    begin
                        it.data = syn_byte;
                    end
                end
                default:
                begin
                    case ($urandom_range(0, 2))
                        0: it.data = arb_addr;
                        1: it.data = {any_master_nibble(), any_master_nibble()};
                        default:
                        begin
                        end
                    endcase
                end
            endcase
        end
        return it;
    endfunction

    // drives one input transaction, possibly after an idle burst, and books its
    // expected status once the block has taken it
    task automatic send(input item_t it, input logic typed, input status_t want);
        status_t st;
        int gap;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= it.op;
        bus_byte <= it.data;
        own_address <= it.addr;
        external <= it.ext;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        st = arbitrate(it);
        status_due.push_back(typed ? want : st);
        if (it.op <= OP_RESTART)
        begin
            items_sent++;
        end
    endtask

    // register write, only once every owed result is back
    task automatic write_reg(input logic idx, input logic [7:0] val);
        while (status_due.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == CFG_MAX_LOCK)
        begin
            lock_max = (val[4:0] > LOCK_LIMIT[4:0]) ? LOCK_LIMIT[4:0] : val[4:0];
            if (lock_cnt > lock_max)
            begin
                lock_cnt = lock_max;
            end
        end
        else
        begin
            syn_byte = val;
        end
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic row_t stim(input logic [2:0] op, input logic [7:0] data,
                                  input logic [7:0] addr, input logic ext);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.it = '{op: op, data: data, addr: addr, ext: ext};
        return r;
    endfunction

    function automatic row_t stim_exp(input logic [2:0] op, input logic [7:0] data,
                                      input logic [7:0] addr, input logic ext,
                                      input status_t want);
        row_t r;
        r = stim(op, data, addr, ext);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic row_t reg_row(input logic idx, input logic [7:0] val);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic status_t outcome(input logic [3:0] code, input logic pending,
                                        input logic [4:0] lock, input logic [1:0] ph,
                                        input logic free, input logic to_h,
                                        input logic to_e);
        return '{code: code, pending: pending, lock: lock, phase: ph, free: free,
                 to_handler: to_h, to_external: to_e};
    endfunction

    // ------------------------------------------------------------------
    // result checking and result-side stalls
    // ------------------------------------------------------------------

    task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d", field, checked,
                 got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin : check_results
        status_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (status_due.size() == 0)
                begin
                    report("result with nothing owed", {4'd0, result_code}, 8'd0);
                end
                else
                begin
                    want = status_due.pop_front();
                    if (result_code !== want.code)
                        report("result_code", {4'd0, result_code}, {4'd0, want.code});
                    if (request_pending !== want.pending)
                        report("request_pending", {7'd0, request_pending},
                               {7'd0, want.pending});
                    if (lock_count !== want.lock)
                        report("lock_count", {3'd0, lock_count}, {3'd0, want.lock});
                    if (phase !== want.phase)
                        report("phase", {6'd0, phase}, {6'd0, want.phase});
                    if (bus_free !== want.free)
                        report("bus_free", {7'd0, bus_free}, {7'd0, want.free});
                    if (notify_handler !== want.to_handler)
                        report("notify_handler", {7'd0, notify_handler},
                               {7'd0, want.to_handler});
                    if (notify_external !== want.to_external)
                        report("notify_external", {7'd0, notify_external},
                               {7'd0, want.to_external});
                    codes_seen[result_code] = 1'b1;
                    checked++;
                end
            end
            // stall bursts on the result side
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(1, 10) - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_sequence
        row_t plan [$];
        logic [7:0] lock_val;
        logic [7:0] syn_val;
        int target;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset values, refused request, ignored opcode and restart
        plan.push_back(stim_exp(OP_BYTE, 8'h00, 8'h00, 1'b0,
                       outcome(RC_OBSERVE_DATA, 1'b0, 5'd25, PH_OBSERVE, 1'b0, 1'b0, 1'b0)));
        plan.push_back(stim_exp(OP_BYTE, 8'hAA, 8'h00, 1'b0,
                       outcome(RC_OBSERVE_SYN, 1'b0, 5'd24, PH_OBSERVE, 1'b0, 1'b0, 1'b0)));
        plan.push_back(stim_exp(OP_REQUEST, 8'h00, 8'hFF, 1'b1,
                       outcome(RC_OBSERVE_SYN, 1'b0, 5'd24, PH_OBSERVE, 1'b0, 1'b0, 1'b0)));
        plan.push_back(stim_exp(OP_UNUSED, 8'hFF, 8'hFF, 1'b1,
                       outcome(RC_OBSERVE_SYN, 1'b0, 5'd24, PH_OBSERVE, 1'b0, 1'b0, 1'b0)));
        plan.push_back(stim_exp(OP_RESTART, 8'h00, 8'h00, 1'b0,
                       outcome(RC_OBSERVE_SYN, 1'b0, 5'd25, PH_OBSERVE, 1'b0, 1'b0, 1'b0)));
        // oversized lock limit is clamped, then zero drops the running counter
        plan.push_back(reg_row(CFG_MAX_LOCK, 8'hFF));
        plan.push_back(reg_row(CFG_MAX_LOCK, 8'h00));
        // handler request, then a retry that ends in a retry error
        plan.push_back(stim_exp(OP_REQUEST, 8'h00, 8'h13, 1'b0,
                       outcome(RC_OBSERVE_SYN, 1'b1, 5'd0, PH_OBSERVE, 1'b0, 1'b0, 1'b0)));
        plan.push_back(stim_exp(OP_SENT, 8'h00, 8'h00, 1'b0,
                       outcome(RC_OBSERVE_SYN, 1'b0, 5'd0, PH_FIRST, 1'b1, 1'b1, 1'b0)));
        plan.push_back(stim(OP_BYTE, 8'hAA, 8'h00, 1'b0));
        plan.push_back(stim(OP_BYTE, 8'h73, 8'h00, 1'b0));
        plan.push_back(stim(OP_BYTE, 8'h55, 8'h00, 1'b0));
        plan.push_back(stim_exp(OP_START_ERR, 8'h00, 8'h00, 1'b0,
                       outcome(RC_OBSERVE_SYN, 1'b0, 5'd0, PH_OBSERVE, 1'b1, 1'b0, 1'b0)));
        // external request through retry to a lost second round, then won
        plan.push_back(stim(OP_REQUEST, 8'h00, 8'hF7, 1'b1));
        plan.push_back(stim(OP_SENT, 8'h00, 8'h00, 1'b0));
        plan.push_back(stim(OP_BYTE, 8'h37, 8'h00, 1'b0));
        plan.push_back(stim(OP_BYTE, 8'hAA, 8'h00, 1'b0));
        plan.push_back(stim(OP_BYTE, 8'h17, 8'h00, 1'b0));
        plan.push_back(stim(OP_BYTE, 8'hAA, 8'h00, 1'b0));
        plan.push_back(stim(OP_SENT, 8'h00, 8'h00, 1'b0));
        plan.push_back(stim(OP_BYTE, 8'hF7, 8'h00, 1'b0));
        // lowest address loses to a master with another low nibble
        plan.push_back(stim(OP_START_ERR, 8'h00, 8'h00, 1'b0));
        plan.push_back(stim(OP_REQUEST, 8'h00, 8'h00, 1'b0));
        plan.push_back(stim(OP_SENT, 8'h00, 8'h00, 1'b0));
        plan.push_back(stim(OP_BYTE, 8'hFF, 8'h00, 1'b0));
        plan.push_back(stim(OP_BYTE, 8'hAA, 8'h00, 1'b0));

        idle_odds = 4;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                in_valid <= 1'b0;
                write_reg(plan[i].cfg_idx, plan[i].cfg_val);
            end
            else
            begin
                send(plan[i].it, plan[i].typed, plan[i].want);
            end
        end
        directed_items = items_sent;

        // random phases, each with its own register setting and idling rate;
        // the first and the last run without idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            in_valid <= 1'b0;
            case (p)
                0:
                begin
                    lock_val = 8'h00;
                    syn_val = 8'hAA;
                end
                1:
                begin
                    lock_val = 8'hFF;
                    syn_val = 8'h00;
                end
                2:
                begin
                    lock_val = 8'h01;
                    syn_val = 8'hFF;
                end
                3:
                begin
                    lock_val = 8'h03;
                    syn_val = 8'h55;
                end
                4:
                begin
                    lock_val = 8'($urandom_range(0, 255));
                    syn_val = 8'($urandom_range(0, 255));
                end
                5:
                begin
                    lock_val = 8'h02;
                    syn_val = 8'h13;
                end
                6:
                begin
                    lock_val = 8'hE0;
                    syn_val = 8'h37;
                end
                default:
                begin
                    lock_val = 8'h19;
                    syn_val = 8'hAA;
                end
            endcase
            write_reg(CFG_MAX_LOCK, lock_val);
            write_reg(CFG_SYN, syn_val);
            idle_odds = (p == 0 || p == RANDOM_PHASES - 1) ? 0 : $urandom_range(3, 12);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                send(next_item(), 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        // drain, then leave room for any stray result
        while (status_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("%0d transactions sent (%0d directed), %0d results checked, %0d register writes",
                 items_sent, directed_items, checked, reg_writes);
        $display("%0d of 12 result codes seen, %0d mismatches", $countones(codes_seen), errors);
        if (errors == 0)
        begin
            $display("bus_arbitration_requester verification clean");
        end
        else
        begin
            $display("bus_arbitration_requester verification failed");
        end
        $finish;
    end

endmodule
